>>> src/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16LE transcoder.
// Used by the front decoder, the command queue, the back emitter and the top level.
package u8u16_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0]  BOM_BYTE0   = 8'hEF;
   localparam logic [7:0]  BOM_BYTE1   = 8'hBB;
   localparam logic [7:0]  BOM_BYTE2   = 8'hBF;
   localparam logic [15:0] HI_SURR     = 16'hD800;
   localparam logic [15:0] LO_SURR     = 16'hDC00;
   localparam logic [20:0] SUPP_BASE   = 21'h10000;

   localparam logic [3:0]  LEAD_FOUR   = 4'hF;
   localparam logic [3:0]  LEAD_THREE  = 4'hE;
   localparam logic [3:0]  LEAD_TWO_HI = 4'hD;
   localparam logic [3:0]  LEAD_TWO_LO = 4'hC;

   localparam logic [2:0]  SEQ_NONE    = 3'd0;
   localparam logic [2:0]  SEQ_TWO     = 3'd2;
   localparam logic [2:0]  SEQ_THREE   = 3'd3;
   localparam logic [2:0]  SEQ_FOUR    = 3'd4;

   typedef struct packed {
      logic [15:0] unit_value;
      logic        status_flag;
      logic        success;
   } rslt_type;

   // Up to three results caused by one input byte, in emission order
   typedef struct packed {
      rslt_type    slot0;
      rslt_type    slot1;
      rslt_type    slot2;
      logic [1:0]  last_idx;
   } cmd_type;

endpackage

>>> src/u8u16_front.sv
// Front decoder: accepts UTF-8 bytes, tracks sequence state and builds result commands.
// Depends on u8u16_pkg.
module u8u16_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         byte_value,
   input  logic               end_of_string,
   output logic               cmd_push,
   output u8u16_pkg::cmd_type cmd
);

   logic [1:0]  pend_ff,  pend_in;
   logic [20:0] code_ff,  code_in;
   logic [2:0]  seq_ff,   seq_in;
   logic        first_ff, first_in;
   logic        err_ff,   err_in;
   logic        bom_ff,   bom_in;

   always_comb begin
      logic [20:0]          joined;
      logic [20:0]          offs;
      logic [1:0]           pend_dec;
      logic                 bom_keep;
      logic [1:0]           nres;
      u8u16_pkg::rslt_type  u0;
      u8u16_pkg::rslt_type  u1;
      u8u16_pkg::rslt_type  st;
      logic                 has_u0;
      logic                 has_u1;

      pend_in  = pend_ff;
      code_in  = code_ff;
      seq_in   = seq_ff;
      first_in = first_ff;
      err_in   = err_ff;
      bom_in   = bom_ff;
      has_u0   = 1'b0;
      has_u1   = 1'b0;
      u0       = '0;
      u1       = '0;
      st       = '0;
      joined   = {code_ff[14:0], byte_value[5:0]};
      offs     = joined - u8u16_pkg::SUPP_BASE;
      pend_dec = pend_ff - 2'd1;
      bom_keep = bom_ff;

      if (pend_ff == 2'd0) begin
         first_in = 1'b0;
         bom_in   = 1'b0;
         if (!byte_value[7]) begin
            has_u0        = 1'b1;
            u0.unit_value = {8'd0, byte_value};
         end else begin
            case (byte_value[7:4])
               u8u16_pkg::LEAD_FOUR: begin
                  code_in = {18'd0, byte_value[2:0]};
                  seq_in  = u8u16_pkg::SEQ_FOUR;
                  pend_in = 2'd3;
               end
               u8u16_pkg::LEAD_THREE: begin
                  code_in = {17'd0, byte_value[3:0]};
                  seq_in  = u8u16_pkg::SEQ_THREE;
                  pend_in = 2'd2;
                  bom_in  = first_ff && (byte_value == u8u16_pkg::BOM_BYTE0);
               end
               u8u16_pkg::LEAD_TWO_HI, u8u16_pkg::LEAD_TWO_LO: begin
                  code_in = {16'd0, byte_value[4:0]};
                  seq_in  = u8u16_pkg::SEQ_TWO;
                  pend_in = 2'd1;
               end
               default: begin
                  // stray continuation byte where a lead is expected
                  err_in = 1'b1;
               end
            endcase
         end
      end else begin
         code_in = joined;
         if (seq_ff == u8u16_pkg::SEQ_THREE && pend_ff == 2'd2
             && byte_value != u8u16_pkg::BOM_BYTE1) begin
            bom_keep = 1'b0;
         end
         bom_in  = bom_keep;
         pend_in = pend_dec;
         if (pend_dec == 2'd0) begin
            if (seq_ff == u8u16_pkg::SEQ_THREE && bom_keep
                && byte_value == u8u16_pkg::BOM_BYTE2 && !end_of_string) begin
               // drop the leading byte order mark
            end else if (seq_ff == u8u16_pkg::SEQ_FOUR && joined >= u8u16_pkg::SUPP_BASE) begin
               has_u0        = 1'b1;
               has_u1        = 1'b1;
               u0.unit_value = {5'd0, offs[20:10]} | u8u16_pkg::HI_SURR;
               u1.unit_value = {6'd0, offs[9:0]} | u8u16_pkg::LO_SURR;
            end else begin
               has_u0        = 1'b1;
               u0.unit_value = joined[15:0];
            end
            bom_in  = 1'b0;
            code_in = '0;
            seq_in  = u8u16_pkg::SEQ_NONE;
         end
      end

      st.status_flag = 1'b1;
      st.success     = !(err_in || pend_in != 2'd0);

      // pack results into slots in order: units first, then status
      cmd = '0;
      nres = 2'd0;
      if (has_u0) begin
         cmd.slot0 = u0;
         if (has_u1) begin
            cmd.slot1 = u1;
            cmd.slot2 = st;
            nres      = end_of_string ? 2'd3 : 2'd2;
         end else begin
            cmd.slot1 = st;
            nres      = end_of_string ? 2'd2 : 2'd1;
         end
      end else begin
         cmd.slot0 = st;
         nres      = end_of_string ? 2'd1 : 2'd0;
      end
      cmd.last_idx = nres - 2'd1;
      cmd_push     = accept && (nres != 2'd0);

      if (end_of_string) begin
         pend_in  = 2'd0;
         code_in  = '0;
         seq_in   = u8u16_pkg::SEQ_NONE;
         first_in = 1'b1;
         err_in   = 1'b0;
         bom_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 2'd0;
         code_ff  <= '0;
         seq_ff   <= u8u16_pkg::SEQ_NONE;
         first_ff <= 1'b1;
         err_ff   <= 1'b0;
         bom_ff   <= 1'b0;
      end else if (accept) begin
         pend_ff  <= pend_in;
         code_ff  <= code_in;
         seq_ff   <= seq_in;
         first_ff <= first_in;
         err_ff   <= err_in;
         bom_ff   <= bom_in;
      end
   end

endmodule

>>> src/u8u16_queue.sv
// Short command queue between the front decoder and the back emitter.
// Depends on u8u16_pkg.
module u8u16_queue #(
   parameter int DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  u8u16_pkg::cmd_type push_cmd,
   output logic               q_full,
   input  logic               pop,
   output logic               q_valid,
   output u8u16_pkg::cmd_type head_cmd
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   u8u16_pkg::cmd_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign q_full   = (cnt_ff == FULL_CNT);
   assign q_valid  = (cnt_ff != '0);
   assign head_cmd = entry_ff[rd_ff];
   assign do_push  = push && !q_full;
   assign do_pop   = pop && q_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

>>> src/u8u16_back.sv
// Back emitter: walks the result slots of the head command into the output register.
// Depends on u8u16_pkg.
module u8u16_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  u8u16_pkg::cmd_type head_cmd,
   output logic               q_pop,
   output logic               out_valid,
   input  logic               out_take,
   output u8u16_pkg::rslt_type out_rslt,
   output logic               out_last
);

   logic [1:0]          idx_ff, idx_in;
   logic                valid_ff, valid_in;
   u8u16_pkg::rslt_type rslt_ff, rslt_in;
   logic                last_ff, last_in;
   logic                load;
   logic                at_last;

   assign load      = q_valid && (!valid_ff || out_take);
   assign at_last   = (idx_ff == head_cmd.last_idx);
   assign q_pop     = load && at_last;
   assign out_valid = valid_ff;
   assign out_rslt  = rslt_ff;
   assign out_last  = last_ff;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      rslt_in  = rslt_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         last_in  = at_last;
         case (idx_ff)
            2'd0:    rslt_in = head_cmd.slot0;
            2'd1:    rslt_in = head_cmd.slot1;
            default: rslt_in = head_cmd.slot2;
         endcase
         // advance within the command, or move on to the next one
         idx_in = at_last ? 2'd0 : idx_ff + 2'd1;
      end else if (out_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rslt_ff <= rslt_in;
      last_ff <= last_in;
   end

endmodule

>>> src/utf8_to_utf16le_transcoder_unit.sv
// UTF-8 to UTF-16LE transcoder, top level: front decoder, command queue, back emitter.
// Path: a byte's results are held as one command in the queue, then loaded one at a time into the output register.
// Throughput: one byte per cycle while the queue is not full; the back emitter sends one result
// per cycle while the receiver pops, so a byte giving two or three results holds it longer and the queue absorbs this.
// Reset: synchronous; clears decoder state, queue pointers and the output valid flag.
module utf8_to_utf16le_transcoder_unit #(
   parameter int QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_byte_value,
   input  logic        req_end_of_string,
   output logic        empty,
   input  logic        pop,
   output logic [15:0] rsp_unit_value,
   output logic        rsp_status_flag,
   output logic        rsp_success,
   output logic        rsp_run_end
);

   u8u16_pkg::cmd_type  new_cmd;
   u8u16_pkg::cmd_type  head_cmd;
   u8u16_pkg::rslt_type out_rslt;
   logic                cmd_push;
   logic                q_full;
   logic                q_valid;
   logic                q_pop;
   logic                out_valid;
   logic                accept;

   assign full   = q_full;
   assign accept = push && !q_full;

   u8u16_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .byte_value    (req_byte_value),
      .end_of_string (req_end_of_string),
      .cmd_push      (cmd_push),
      .cmd           (new_cmd)
   );

   u8u16_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (new_cmd),
      .q_full   (q_full),
      .pop      (q_pop),
      .q_valid  (q_valid),
      .head_cmd (head_cmd)
   );

   u8u16_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .head_cmd  (head_cmd),
      .q_pop     (q_pop),
      .out_valid (out_valid),
      .out_take  (pop),
      .out_rslt  (out_rslt),
      .out_last  (rsp_run_end)
   );

   assign empty           = !out_valid;
   assign rsp_unit_value  = out_rslt.unit_value;
   assign rsp_status_flag = out_rslt.status_flag;
   assign rsp_success     = out_rslt.success;

endmodule

>>> tb/transcode_monitor.sv
`timescale 1ns / 1ps
// Monitor for the UTF-8 to UTF-16LE transcoder: predicts the units and status results
// of every byte transfer and checks them in order. Depends on u8u16_pkg.
module transcode_monitor (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [7:0]  req_byte_value,
   input  logic        req_end_of_string,
   input  logic        empty,
   input  logic        pop,
   input  logic [15:0] rsp_unit_value,
   input  logic        rsp_status_flag,
   input  logic        rsp_success,
   input  logic        rsp_run_end,
   output int          fail_count,
   output int          pending_results,
   output int          results_checked
);

   typedef struct packed {
      logic [15:0] unit_value;
      logic        status_flag;
      logic        success;
      logic        run_end;
   } unit_rec_type;

   unit_rec_type expected_units[$];

   // decoder state for the string in progress
   logic [1:0]  cont_left;
   logic [20:0] code_acc;
   logic [2:0]  seq_len;
   logic        at_string_start;
   logic        string_err;
   logic        bom_live;

   function automatic unit_rec_type make_rec(input logic [15:0] v, input logic st,
                                             input logic ok);
      unit_rec_type r;
      r.unit_value  = v;
      r.status_flag = st;
      r.success     = ok;
      r.run_end     = 1'b0;
      return r;
   endfunction

   task automatic clear_string;
      cont_left       = 2'd0;
      code_acc        = 21'd0;
      seq_len         = u8u16_pkg::SEQ_NONE;
      at_string_start = 1'b1;
      string_err      = 1'b0;
      bom_live        = 1'b0;
   endtask

   task automatic transcode_byte(input logic [7:0] b, input logic eos);
      unit_rec_type found[$];
      logic         opens;
      logic [20:0]  offs;
      if (cont_left == 2'd0) begin
         opens           = at_string_start;
         at_string_start = 1'b0;
         bom_live        = 1'b0;
         if (!b[7]) begin
            found.insert(found.size(), make_rec({8'd0, b}, 1'b0, 1'b0));
         end else begin
            case (b[7:4])
               u8u16_pkg::LEAD_FOUR: begin
                  code_acc  = {18'd0, b[2:0]};
                  seq_len   = u8u16_pkg::SEQ_FOUR;
                  cont_left = 2'd3;
               end
               u8u16_pkg::LEAD_THREE: begin
                  code_acc  = {17'd0, b[3:0]};
                  seq_len   = u8u16_pkg::SEQ_THREE;
                  cont_left = 2'd2;
                  bom_live  = opens && (b == u8u16_pkg::BOM_BYTE0);
               end
               u8u16_pkg::LEAD_TWO_HI, u8u16_pkg::LEAD_TWO_LO: begin
                  code_acc  = {16'd0, b[4:0]};
                  seq_len   = u8u16_pkg::SEQ_TWO;
                  cont_left = 2'd1;
               end
               default: string_err = 1'b1;   // stray continuation byte as lead
            endcase
         end
      end else begin
         code_acc = {code_acc[14:0], b[5:0]};
         if (seq_len == u8u16_pkg::SEQ_THREE && cont_left == 2'd2
             && b != u8u16_pkg::BOM_BYTE1)
            bom_live = 1'b0;
         cont_left = cont_left - 2'd1;
         if (cont_left == 2'd0) begin
            if (seq_len == u8u16_pkg::SEQ_THREE && bom_live
                && b == u8u16_pkg::BOM_BYTE2 && !eos) begin
               // drop the leading byte order mark
            end else if (seq_len == u8u16_pkg::SEQ_FOUR
                         && code_acc >= u8u16_pkg::SUPP_BASE) begin
               offs = code_acc - u8u16_pkg::SUPP_BASE;
               found.insert(found.size(),
                            make_rec({5'd0, offs[20:10]} | u8u16_pkg::HI_SURR, 1'b0, 1'b0));
               found.insert(found.size(),
                            make_rec({6'd0, offs[9:0]} | u8u16_pkg::LO_SURR, 1'b0, 1'b0));
            end else begin
               found.insert(found.size(), make_rec(code_acc[15:0], 1'b0, 1'b0));
            end
            bom_live = 1'b0;
            code_acc = 21'd0;
            seq_len  = u8u16_pkg::SEQ_NONE;
         end
      end
      if (eos) begin
         if (cont_left != 2'd0)
            string_err = 1'b1;
         found.insert(found.size(), make_rec(16'd0, 1'b1, !string_err));
         clear_string();
      end
      for (int i = 0; i < found.size(); i++) begin
         found[i].run_end = (i == found.size() - 1);
         expected_units.insert(expected_units.size(), found[i]);
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, actual %h", name, want, got);
         fail_count++;
      end
   endtask

   task automatic compare_result;
      unit_rec_type want;
      if (expected_units.size() == 0) begin
         $error("result with nothing expected: unit_value %h status_flag %b",
                rsp_unit_value, rsp_status_flag);
         fail_count++;
      end else begin
         want = expected_units.pop_front();
         check_field("unit_value", want.unit_value, rsp_unit_value);
         check_field("status_flag", {15'd0, want.status_flag}, {15'd0, rsp_status_flag});
         check_field("success", {15'd0, want.success}, {15'd0, rsp_success});
         check_field("run_end", {15'd0, want.run_end}, {15'd0, rsp_run_end});
         results_checked++;
      end
   endtask

   initial begin
      fail_count      = 0;
      pending_results = 0;
      results_checked = 0;
      clear_string();
   end

   always @(posedge clock) begin
      if (reset) begin
         expected_units.delete();
         clear_string();
      end else begin
         if (pop && !empty)
            compare_result();
         if (push && !full)
            transcode_byte(req_byte_value, req_end_of_string);
      end
      pending_results = expected_units.size();
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Top of the transcoder testbench: clock, reset, UTF-8 string stimulus and result pops.
// Depends on u8u16_pkg, the transcoder top level and transcode_monitor.
module tb;

   logic        clock = 1'b0;
   logic        reset;
   logic        push;
   logic        full;
   logic [7:0]  req_byte_value;
   logic        req_end_of_string;
   logic        empty;
   logic        pop;
   logic [15:0] rsp_unit_value;
   logic        rsp_status_flag;
   logic        rsp_success;
   logic        rsp_run_end;

   int   fail_count;
   int   pending_results;
   int   results_checked;

   logic       hold_req;
   logic       hold_taken;
   logic       gaps_on;
   int         burst_left;
   int         bytes_sent;
   int         strings_sent;
   logic [7:0] text_q[$];

   always #6 clock = ~clock;

   utf8_to_utf16le_transcoder_unit dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_byte_value    (req_byte_value),
      .req_end_of_string (req_end_of_string),
      .empty             (empty),
      .pop               (pop),
      .rsp_unit_value    (rsp_unit_value),
      .rsp_status_flag   (rsp_status_flag),
      .rsp_success       (rsp_success),
      .rsp_run_end       (rsp_run_end)
   );

   transcode_monitor mon (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_byte_value    (req_byte_value),
      .req_end_of_string (req_end_of_string),
      .empty             (empty),
      .pop               (pop),
      .rsp_unit_value    (rsp_unit_value),
      .rsp_status_flag   (rsp_status_flag),
      .rsp_success       (rsp_success),
      .rsp_run_end       (rsp_run_end),
      .fail_count        (fail_count),
      .pending_results   (pending_results),
      .results_checked   (results_checked)
   );

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      if (gaps_on && burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            @(negedge clock) push <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      if (burst_left > 0)
         burst_left--;
      @(negedge clock);
      push              <= 1'b1;
      req_byte_value    <= b;
      req_end_of_string <= last;
      do @(posedge clock); while (full);
      bytes_sent++;
   endtask

   task automatic send_text;
      for (int i = 0; i < text_q.size(); i++)
         send_byte(text_q[i], i == text_q.size() - 1);
      strings_sent++;
      text_q.delete();
   endtask

   // Stop offering and hold until every expected result has been popped
   task automatic drain;
      @(negedge clock) push <= 1'b0;
      while (pending_results != 0) @(negedge clock);
   endtask

   function automatic logic [7:0] rand_cont;
      if ($urandom_range(0, 7) == 0)
         return 8'($urandom_range(0, 255));
      return 8'h80 | 8'($urandom_range(0, 63));
   endfunction

   task automatic add_sequence;
      int kind;
      kind = $urandom_range(0, 19);
      if (kind < 6) begin
         text_q.insert(text_q.size(), 8'($urandom_range(0, 127)));
      end else if (kind < 10) begin
         text_q.insert(text_q.size(), 8'hC0 | 8'($urandom_range(0, 31)));
         text_q.insert(text_q.size(), rand_cont());
      end else if (kind < 14) begin
         text_q.insert(text_q.size(), 8'hE0 | 8'($urandom_range(0, 15)));
         repeat (2) text_q.insert(text_q.size(), rand_cont());
      end else if (kind < 18) begin
         text_q.insert(text_q.size(), 8'hF0 | 8'($urandom_range(0, 15)));
         repeat (3) text_q.insert(text_q.size(), rand_cont());
      end else begin
         text_q.insert(text_q.size(), 8'h80 | 8'($urandom_range(0, 63)));
      end
   endtask

   // Mostly well-formed strings; some open with a byte order mark or a spoilt one,
   // some are cut short inside a sequence
   task automatic build_random_text;
      int pick;
      int count;
      pick  = $urandom_range(0, 9);
      count = $urandom_range(1, 5);
      if (pick < 2) begin
         text_q = {u8u16_pkg::BOM_BYTE0, u8u16_pkg::BOM_BYTE1, u8u16_pkg::BOM_BYTE2};
         count  = $urandom_range(0, 5);
      end else if (pick == 2) begin
         text_q = {u8u16_pkg::BOM_BYTE0,
                   ($urandom_range(0, 1) ? u8u16_pkg::BOM_BYTE1 : 8'hBA),
                   ($urandom_range(0, 1) ? u8u16_pkg::BOM_BYTE2 : 8'hBE)};
      end
      repeat (count) add_sequence();
      if ($urandom_range(0, 6) == 0)
         repeat ($urandom_range(1, 2))
            if (text_q.size() > 1) void'(text_q.pop_back());
   endtask

   initial begin
      reset             = 1'b1;
      push              = 1'b0;
      req_byte_value    = 8'd0;
      req_end_of_string = 1'b0;
      hold_req          = 1'b0;
      gaps_on           = 1'b1;
      burst_left        = 0;
      bytes_sent        = 0;
      strings_sent      = 0;
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // ASCII extremes
      text_q = {8'h00, 8'h7F};
      send_text();
      // leading byte order mark, dropped
      text_q = {u8u16_pkg::BOM_BYTE0, u8u16_pkg::BOM_BYTE1, u8u16_pkg::BOM_BYTE2, 8'h41};
      send_text();
      // string ending on the mark keeps it
      text_q = {u8u16_pkg::BOM_BYTE0, u8u16_pkg::BOM_BYTE1, u8u16_pkg::BOM_BYTE2};
      send_text();
      // two-byte top, surrogate pair, four-byte maximum with the last byte giving three
      text_q = {8'hDF, 8'hBF, 8'hF0, 8'h90, 8'h80, 8'h80, 8'hFF, 8'hBF, 8'hBF, 8'hBF};
      send_text();
      // four-byte sequence below the supplementary range
      text_q = {8'hF0, 8'h80, 8'h80, 8'h41};
      send_text();
      // stray continuation byte where a lead is expected, then the lowest two-byte lead
      text_q = {8'h80, 8'hC0, 8'h80};
      send_text();
      // string ends inside a sequence
      text_q = {8'hE1, 8'h80};
      send_text();
      drain();

      // receiver holds off while the sender keeps offering back to back
      hold_req = 1'b1;
      gaps_on  = 1'b0;
      while (bytes_sent < 50) begin
         build_random_text();
         send_text();
      end
      drain();

      gaps_on = 1'b1;
      while (bytes_sent < 125) begin
         build_random_text();
         send_text();
      end
      drain();
      repeat (10) @(negedge clock);

      $display("Sent %0d strings (%0d bytes): marks, surrogates, stray leads, early ends;",
               strings_sent, bytes_sent);
      $display("compared %0d results under bursty input and stalled output.", results_checked);
      if (fail_count == 0 && pending_results == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Receiver: stall pattern steps through four modes in turn, with one long hold-off
   initial begin
      int cyc;
      cyc        = 0;
      pop        = 1'b0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            pop <= 1'b0;
            repeat (48) @(negedge clock);
         end else begin
            case ((cyc / 64) % 4)
               0:       pop <= 1'b1;
               1:       pop <= 1'($urandom_range(0, 1));
               2:       pop <= ($urandom_range(0, 3) == 0);
               default: pop <= ($urandom_range(0, 7) != 0);
            endcase
            cyc++;
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
